// File: rtl/core/bb26_pkg.sv
// Shared constants, types and divide-by-26 helper for the base-26 label encoder.
`timescale 1ns / 1ps
`default_nettype none

package bb26_pkg;

    // Default depth of the letter stack
    localparam int LETTER_BUFFER_DEPTH_DEF = 16;

    // Field widths
    localparam int VALUE_W  = 64;
    localparam int LETTER_W = 7;
    localparam int LENGTH_W = 5;
    localparam int MAXL_W   = 5;
    localparam int DIGIT_W  = 5;

    // Long division by 26 runs over 16-bit chunks, most significant first
    localparam int CHUNK_W    = 16;
    localparam int NUM_CHUNKS = VALUE_W / CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(NUM_CHUNKS);
    localparam int PART_W     = DIGIT_W + CHUNK_W;

    localparam logic [MAXL_W-1:0]   MAX_LETTERS_RST = 5'd16;
    localparam logic [LETTER_W-1:0] LETTER_A        = 7'd97;
    localparam logic [DIGIT_W-1:0]  RADIX           = 5'd26;

    // Reciprocal of 26 scaled by 2^26; exact enough for a 21-bit dividend
    localparam int RECIP_SHIFT = 26;
    localparam logic [21:0] RECIP_26 = 22'd2581110;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // take a new number
        logic div_step;    // divide one chunk by 26
        logic dec;         // subtract one from the quotient, start next digit
        logic push;        // push the finished digit onto the stack
        logic pop;         // move the top letter into the output register
        logic emit_empty;  // load the empty-label result
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic neg;         // incoming number is negative
        logic quot_zero;   // quotient after a full division is zero
        logic at_limit;    // the digit being pushed reaches the letter limit
        logic last_pop;    // one letter left on the stack
        logic out_free;    // output register can take a result this cycle
    } status_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] quot;
        logic [DIGIT_W-1:0] rem;
    } div26_t;

    // Divide a partial dividend (remainder below 26 over one chunk) by 26
    function automatic div26_t div26(input logic [PART_W-1:0] x);
        logic [PART_W+22-1:0] prod;
        logic [CHUNK_W-1:0]   q0;
        logic [PART_W-1:0]    back;
        logic [PART_W-1:0]    r0;
        div26_t               res;
        prod = x * RECIP_26;
        q0   = prod[RECIP_SHIFT +: CHUNK_W];
        back = ({5'd0, q0} << 4) + ({5'd0, q0} << 3) + ({5'd0, q0} << 1);
        r0   = x - back;
        if (r0 >= PART_W'(RADIX)) begin
            res.quot = q0 + 16'd1;
            res.rem  = DIGIT_W'(r0 - PART_W'(RADIX));
        end
        else begin
            res.quot = q0;
            res.rem  = DIGIT_W'(r0);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bb26_ifs.sv
// Valid/ready channel interfaces for numbers in and letters out.
`timescale 1ns / 1ps
`default_nettype none

interface bb26_num_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bb26_label_if;
    logic       valid;
    logic       ready;
    logic [6:0] letter;
    logic       empty_res;
    logic       last;
    logic [4:0] length;

    modport source (output valid, output letter, output empty_res, output last,
                    output length, input ready);
    modport sink   (input valid, input letter, input empty_res, input last,
                    input length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bb26_ctrl.sv
// Sequencing state machine for the base-26 label encoder.
`timescale 1ns / 1ps
`default_nettype none

module bb26_ctrl
    import bb26_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CHUNK_CNT_W-1:0] chunk_reg, chunk_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        chunk_next = chunk_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    chunk_next = '0;
                    state_next = status.neg ? ST_EMPTY : ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                chunk_next   = chunk_reg + 1'b1;
                if (chunk_reg == CHUNK_CNT_W'(NUM_CHUNKS - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.push = 1'b1;
                if (status.quot_zero || status.at_limit)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.dec    = 1'b1;
                    chunk_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.pop = 1'b1;
                    if (status.last_pop)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chunk_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bb26_datapath.sv
// Chunked divide-by-26 datapath, letter stack and output register.
`timescale 1ns / 1ps
`default_nettype none

module bb26_datapath
    import bb26_pkg::*;
#(
    parameter int LETTER_BUFFER_DEPTH = LETTER_BUFFER_DEPTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [MAXL_W-1:0]         cfg_wr_data,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire cmd_t                      cmd,
    output status_t                        status,
    bb26_label_if.source                   label
);

    localparam int CNT_W = $clog2(LETTER_BUFFER_DEPTH + 1);

    logic [MAXL_W-1:0]   max_letters_reg, max_letters_next;
    logic [VALUE_W-1:0]  m_reg, m_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [DIGIT_W-1:0]  stack_reg [LETTER_BUFFER_DEPTH];
    logic [DIGIT_W-1:0]  stack_next [LETTER_BUFFER_DEPTH];

    logic                out_valid_reg, out_valid_next;
    logic [LETTER_W-1:0] letter_reg, letter_next;
    logic                empty_reg, empty_next;
    logic                last_reg, last_next;
    logic [LENGTH_W-1:0] length_reg, length_next;

    logic [5:0]          limit;
    div26_t              div_res;

    // Clamp the letter limit to one..depth
    always_comb
    begin
        if (max_letters_reg == '0)
        begin
            limit = 6'd1;
        end
        else if ({1'b0, max_letters_reg} > 6'(LETTER_BUFFER_DEPTH))
        begin
            limit = 6'(LETTER_BUFFER_DEPTH);
        end
        else
        begin
            limit = {1'b0, max_letters_reg};
        end
    end

    assign div_res = div26({rem_reg, m_reg[VALUE_W-1 -: CHUNK_W]});

    assign status.neg       = value[VALUE_W-1];
    assign status.quot_zero = (m_reg == '0);
    assign status.at_limit  = ((6'(count_reg) + 6'd1) == limit);
    assign status.last_pop  = (left_reg == CNT_W'(1));
    assign status.out_free  = !out_valid_reg || label.ready;

    assign max_letters_next = cfg_wr_en ? cfg_wr_data : max_letters_reg;

    // Advance the dividend and remainder
    always_comb
    begin
        m_next   = m_reg;
        rem_next = rem_reg;
        if (cmd.load)
        begin
            m_next   = VALUE_W'(value);
            rem_next = '0;
        end
        else if (cmd.div_step)
        begin
            m_next   = {m_reg[VALUE_W-CHUNK_W-1:0], div_res.quot};
            rem_next = div_res.rem;
        end
        else if (cmd.dec)
        begin
            m_next   = m_reg - VALUE_W'(1);
            rem_next = '0;
        end
    end

    // Push digits least significant first, pop most significant first
    always_comb
    begin
        count_next = count_reg;
        left_next  = left_reg;
        for (int i = 0; i < LETTER_BUFFER_DEPTH; i++)
        begin
            stack_next[i] = stack_reg[i];
        end
        if (cmd.load)
        begin
            count_next = '0;
            left_next  = '0;
        end
        else if (cmd.push)
        begin
            count_next    = count_reg + 1'b1;
            left_next     = left_reg + 1'b1;
            stack_next[0] = rem_reg;
            for (int i = 1; i < LETTER_BUFFER_DEPTH; i++)
            begin
                stack_next[i] = stack_reg[i-1];
            end
        end
        else if (cmd.pop)
        begin
            left_next = left_reg - 1'b1;
            for (int i = 0; i < LETTER_BUFFER_DEPTH - 1; i++)
            begin
                stack_next[i] = stack_reg[i+1];
            end
        end
    end

    // Load or drop the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        letter_next    = letter_reg;
        empty_next     = empty_reg;
        last_next      = last_reg;
        length_next    = length_reg;
        if (cmd.pop)
        begin
            out_valid_next = 1'b1;
            letter_next    = LETTER_A + LETTER_W'(stack_reg[0]);
            empty_next     = 1'b0;
            last_next      = (left_reg == CNT_W'(1));
            length_next    = LENGTH_W'(count_reg);
        end
        else if (cmd.emit_empty)
        begin
            out_valid_next = 1'b1;
            letter_next    = '0;
            empty_next     = 1'b1;
            last_next      = 1'b1;
            length_next    = '0;
        end
        else if (label.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign label.valid     = out_valid_reg;
    assign label.letter    = letter_reg;
    assign label.empty_res = empty_reg;
    assign label.last      = last_reg;
    assign label.length    = length_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_letters_reg <= MAX_LETTERS_RST;
            count_reg       <= '0;
            left_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            max_letters_reg <= max_letters_next;
            count_reg       <= count_next;
            left_reg        <= left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        rem_reg    <= rem_next;
        letter_reg <= letter_next;
        empty_reg  <= empty_next;
        last_reg   <= last_next;
        length_reg <= length_next;
        for (int i = 0; i < LETTER_BUFFER_DEPTH; i++)
        begin
            stack_reg[i] <= stack_next[i];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bijective_base26_encoder.sv
// Top level: a number of L letters takes one transfer, then for each letter four 16-bit
// divide-by-26 passes and one digit check, then L output transfers, each held while the
// output register is full. Labels hold at most 14 letters; a negative number gives
// one empty-label result. The next number is taken once the final result sits in the output register.
// Reset clears the controller and the output valid and sets max_letters back to 16.
`timescale 1ns / 1ps
`default_nettype none

module bijective_base26_encoder
    import bb26_pkg::*;
#(
    parameter int LETTER_BUFFER_DEPTH = LETTER_BUFFER_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [MAXL_W-1:0] cfg_wr_data,
    bb26_num_if.sink               number,
    bb26_label_if.source           label
);

    cmd_t    cmd;
    status_t status;

    // Sequence the division, digit check and emission
    bb26_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (number.valid),
        .in_ready (number.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Divide, stack letters and hold the output
    bb26_datapath #(
        .LETTER_BUFFER_DEPTH (LETTER_BUFFER_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .value       (number.value),
        .cmd         (cmd),
        .status      (status),
        .label       (label)
    );

endmodule

`default_nettype wire

// File: tb/bb26_label_checker.sv
// Checker for the base-26 label encoder: predicts each label and compares every letter.
`timescale 1ns / 1ps

module bb26_label_checker
    import bb26_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [MAXL_W-1:0] cfg_wr_data,
    bb26_num_if               number,
    bb26_label_if             label,
    output int                mismatch_count,
    output int                outstanding,
    output int                results_checked,
    output int                labels_cut
);

    localparam int ALPHABET_SIZE = 26;
    localparam int STACK_DEPTH   = LETTER_BUFFER_DEPTH_DEF;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                empty_res;
        logic                last;
        logic [LENGTH_W-1:0] length;
    } label_result_t;

    label_result_t     expected_letters[$];
    logic [MAXL_W-1:0] letter_limit;

    // Work out the letters for one number and queue them, most significant first
    function automatic void predict_label(input logic [VALUE_W-1:0] raw);
        logic [DIGIT_W-1:0] digits [STACK_DEPTH];
        logic [VALUE_W-1:0] m;
        int                 limit;
        int                 count;
        label_result_t      res;
        if (raw[VALUE_W-1]) begin
            res.letter    = '0;
            res.empty_res = 1'b1;
            res.last      = 1'b1;
            res.length    = '0;
            expected_letters.push_back(res);
            return;
        end
        // Saturate the limit into 1..depth
        limit = int'(letter_limit);
        if (limit < 1)
            limit = 1;
        if (limit > STACK_DEPTH)
            limit = STACK_DEPTH;
        // Peel digits off the low end; each step borrows one before dividing
        m     = raw + 64'd1;
        count = 0;
        while (count < limit) begin
            m             = m - 64'd1;
            digits[count] = DIGIT_W'(m % ALPHABET_SIZE);
            count++;
            m = m / ALPHABET_SIZE;
            if (m == 64'd0)
                break;
        end
        if (m != 64'd0)
            labels_cut++;
        for (int k = 0; k < count; k++) begin
            res.letter    = LETTER_A + LETTER_W'(digits[count - 1 - k]);
            res.empty_res = 1'b0;
            res.last      = (k + 1 == count);
            res.length    = LENGTH_W'(count);
            expected_letters.push_back(res);
        end
    endfunction

    function automatic void report_mismatch(input string what, input label_result_t want,
                                            input label_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t MISMATCH %s: expected letter=%0d empty=%0b last=%0b len=%0d, got letter=%0d empty=%0b last=%0b len=%0d",
                     $realtime, what, want.letter, want.empty_res, want.last, want.length,
                     got.letter, got.empty_res, got.last, got.length);
    endfunction

    // Track the limit register, predict on number transfers, check on label transfers
    always @(posedge clk or negedge rst_n) begin
        label_result_t want;
        label_result_t got;
        if (!rst_n) begin
            letter_limit = MAX_LETTERS_RST;
            expected_letters.delete();
            mismatch_count  = 0;
            results_checked = 0;
            labels_cut      = 0;
            outstanding    <= 0;
        end
        else begin
            if (cfg_wr_en)
                letter_limit = cfg_wr_data;
            if (number.valid && number.ready)
                predict_label(number.value);
            if (label.valid && label.ready) begin
                got.letter    = label.letter;
                got.empty_res = label.empty_res;
                got.last      = label.last;
                got.length    = label.length;
                results_checked++;
                if (expected_letters.size() == 0) begin
                    want = '0;
                    report_mismatch("result with nothing expected", want, got);
                end
                else begin
                    want = expected_letters.pop_front();
                    if (got.letter !== want.letter || got.empty_res !== want.empty_res ||
                        got.last !== want.last || got.length !== want.length)
                        report_mismatch("wrong field", want, got);
                end
            end
            outstanding <= expected_letters.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// Top of the label encoder testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
    import bb26_pkg::*;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_PHASES  = 8;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int DRAIN_CYCLES   = 100;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [MAXL_W-1:0] cfg_wr_data;

    bb26_num_if   number_ch ();
    bb26_label_if label_ch ();

    int mismatch_count;
    int outstanding;
    int results_checked;
    int labels_cut;

    int cycle_count;
    int numbers_sent;
    int negatives_sent;
    int limit_settings;
    int burst_left;
    int hold_requests;
    int holds_served;
    bit offering;
    bit gaps_on;

    bijective_base26_encoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .number      (number_ch),
        .label       (label_ch)
    );

    bb26_label_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .number          (number_ch),
        .label           (label_ch),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .labels_cut      (labels_cut)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Smallest number whose label has the given letter count
    function automatic logic [63:0] label_floor(input int letters);
        logic [63:0] acc;
        logic [63:0] pow;
        acc = 64'd0;
        pow = 64'd1;
        for (int i = 1; i < letters; i++) begin
            pow = pow * 64'd26;
            acc = acc + pow;
        end
        return acc;
    endfunction

    // Mix of negatives, small numbers, length edges, length-targeted and wide numbers
    function automatic logic [63:0] random_number();
        int          pick;
        int          letters;
        logic [63:0] lo;
        logic [63:0] span;
        pick    = $urandom_range(0, 99);
        letters = $urandom_range(1, 14);
        lo      = label_floor(letters);
        if (pick < 12)
            return rand64() | 64'h8000_0000_0000_0000;
        if (pick < 25)
            return 64'($urandom_range(0, 1000));
        if (pick < 35)
            return (letters == 1) ? 64'($urandom_range(0, 1)) : lo + $urandom_range(0, 2) - 1;
        if (pick < 80) begin
            span = (letters == 14) ? (64'h8000_0000_0000_0000 - lo) : (label_floor(15) - lo);
            if (letters < 14)
                span = label_floor(letters + 1) - lo;
            return lo + rand64() % span;
        end
        return rand64() & 64'h7FFF_FFFF_FFFF_FFFF;
    endfunction

    // Offer one number and hold it until transfer; then maybe pause between bursts
    task automatic send_number(input logic [63:0] v);
        int gap;
        number_ch.valid <= 1'b1;
        number_ch.value <= v;
        offering = 1'b1;
        @(posedge clk);
        while (!number_ch.ready)
            @(posedge clk);
        numbers_sent++;
        if (v[63])
            negatives_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && gaps_on) begin
            gap = $urandom_range(1, 12);
            number_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left == 0)
            burst_left = $urandom_range(1, 10);
    endtask

    // Wait for every label to drain, then write the letter limit
    task automatic set_max_letters(input logic [MAXL_W-1:0] v);
        if (offering) begin
            number_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_settings++;
    endtask

    // Receiver: segments of different stall patterns, plus a long hold on request
    initial
    begin
        int pattern;
        int seg_len;
        label_ch.ready <= 1'b0;
        holds_served = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                for (int i = 0; i < LONG_HOLD; i++) begin
                    label_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            pattern = $urandom_range(0, 4);
            seg_len = $urandom_range(10, 120);
            for (int i = 0; i < seg_len; i++) begin
                case (pattern)
                    0: label_ch.ready <= 1'b1;
                    1: label_ch.ready <= ($urandom_range(0, 1) == 0);
                    2: label_ch.ready <= ($urandom_range(0, 99) < 85);
                    3: label_ch.ready <= (i % 4 == 0);
                    default: label_ch.ready <= ($urandom_range(0, 99) < 20);
                endcase
                @(posedge clk);
            end
        end
    end

    // Reset and stimulus
    initial
    begin
        logic [MAXL_W-1:0] phase_limits [RANDOM_PHASES];
        phase_limits = '{5'd1, 5'd16, 5'd13, 5'd14, 5'd7, 5'd0, 5'd31, 5'd20};
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        number_ch.valid <= 1'b0;
        number_ch.value <= '0;
        numbers_sent   = 0;
        negatives_sent = 0;
        limit_settings = 0;
        burst_left     = 1;
        hold_requests  = 0;
        offering       = 1'b0;
        gaps_on        = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: letter boundaries, widest label, negatives, at the reset limit
        send_number(64'd0);
        send_number(64'd1);
        send_number(64'd25);
        send_number(64'd26);
        send_number(64'd27);
        send_number(64'd701);
        send_number(64'd702);
        send_number(64'd18277);
        send_number(64'd18278);
        send_number(label_floor(14) - 64'd1);
        send_number(label_floor(14));
        send_number(64'h7FFF_FFFF_FFFF_FFFF);
        send_number(64'hFFFF_FFFF_FFFF_FFFF);
        send_number(64'h8000_0000_0000_0000);
        send_number(64'hAAAA_5555_0000_FFFF);
        // Zero limit saturates to one letter: keep only the lowest letter
        set_max_letters(5'd0);
        send_number(64'h7FFF_FFFF_FFFF_FFFF);
        send_number(64'd27);
        send_number(64'd0);
        send_number(64'hFFFF_FFFF_FFFF_FFFF);
        // Limit above the stack depth saturates to the depth
        set_max_letters(5'd31);
        send_number(64'h7FFF_FFFF_FFFF_FFFF);
        send_number(64'd702);
        set_max_letters(5'd3);
        send_number(64'd18278);
        send_number(64'd18277);

        // Random phases, one per limit setting; the second one runs without gaps
        // while the receiver holds off, so the encoder backs up into its input
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_max_letters(phase_limits[p]);
            gaps_on = (p != 1);
            if (p == 1)
                hold_requests <= hold_requests + 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_number(random_number());
        end
        gaps_on = 1'b1;

        // Drain
        if (offering) begin
            number_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d numbers (%0d negative) across %0d letter-limit settings.",
                 numbers_sent, negatives_sent, limit_settings + 1);
        $display("Checked %0d letter results; %0d labels were cut to the limit.",
                 results_checked, labels_cut);
        if (mismatch_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
